>>> rtl/maze_junction_graph_extractor_core_macros.svh
// Assertion macros for the maze graph extractor checker.
// Include with the bare file name; no other dependencies.
`ifndef MAZE_JUNCTION_GRAPH_EXTRACTOR_CORE_MACROS_SVH
`define MAZE_JUNCTION_GRAPH_EXTRACTOR_CORE_MACROS_SVH

// same-cycle implication, off while reset is high
`define MJE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, off while reset is high
`define MJE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// next-cycle implication that also watches reset itself
`define MJE_ASSERT_NEXT_ALL(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("reset state check failed");

`endif

>>> rtl/mje_pkg.sv
// Shared types, constants and helpers for the maze graph extractor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mje_pkg;

   localparam int unsigned MAX_WIDTH_DEF  = 1024;
   localparam int unsigned MAX_HEIGHT_DEF = 1024;
   localparam int unsigned CFG_W          = 11;
   localparam int unsigned CFG_RESET_DIM  = 1024;
   localparam int unsigned COORD_W        = 10;
   localparam int unsigned PIXEL_W        = 8;
   localparam int unsigned MIN_DIM        = 3;
   localparam int unsigned CSR_INDEX_W    = 1;

   typedef logic [CFG_W-1:0]   cfg_type;
   typedef logic [COORD_W-1:0] coord_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_START    = 2'd0,
      KIND_INTERIOR = 2'd1,
      KIND_END      = 2'd2
   } node_kind_type;

   typedef struct packed {
      coord_type     row;
      coord_type     col;
      node_kind_type kind;
      logic          has_north;
      coord_type     north_row;
      logic          has_west;
      coord_type     west_col;
   } node_type;

   // everything one pixel produced: one or two nodes
   typedef struct packed {
      logic     valid;
      logic     two;
      node_type first;
      node_type second;
   } bundle_type;

   // last index (dimension - 1) after saturating the written dimension
   function automatic logic [31:0] clamp_last(cfg_type v, int unsigned maxv);
      logic [31:0] v32;
      v32 = 32'(v);
      if (v32 < MIN_DIM) begin
         return MIN_DIM - 1;
      end else if (v32 > maxv) begin
         return maxv - 1;
      end
      return v32 - 32'd1;
   endfunction

endpackage

>>> rtl/maze_junction_graph_extractor_core.sv
// Maze graph extractor. Pixels stream in row-major order, one per clock with
// no gaps needed; the block sustains one pixel per cycle while the result
// queue has room. A pixel's nodes pass the decision register, then the
// queue (the column and line memories are read on intake and decided in
// the decision stage). Interior nodes for row r come out while row r+1
// streams in. A pixel that yields two nodes (bottom row) holds the result
// port for two pops; a two-entry queue between decision and result side
// absorbs short result stalls before full rises. No clearing pass after
// reset: column records are rewritten along row 0 of every frame. Writing
// a dimension restarts the frame. Depends on mje_pkg, mje_front, mje_emit.
`timescale 1ns / 1ps

module maze_junction_graph_extractor_core #(
   parameter int unsigned MAX_WIDTH  = mje_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = mje_pkg::MAX_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [mje_pkg::PIXEL_W-1:0]     req_pixel,
   input  logic                            pop,
   output logic                            empty,
   output logic [mje_pkg::COORD_W-1:0]     rsp_node_row,
   output logic [mje_pkg::COORD_W-1:0]     rsp_node_col,
   output logic [1:0]                      rsp_node_kind,
   output logic                            rsp_has_north,
   output logic [mje_pkg::COORD_W-1:0]     rsp_north_row,
   output logic                            rsp_has_west,
   output logic [mje_pkg::COORD_W-1:0]     rsp_west_col,
   output logic                            rsp_last,
   input  logic                            csr_we,
   input  logic [mje_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mje_pkg::CFG_W-1:0]       csr_wdata
);

   mje_pkg::bundle_type fwd;
   mje_pkg::node_type   rsp_node;
   logic                fwd_stall;

   mje_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_pixel (req_pixel),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fwd       (fwd),
      .fwd_stall (fwd_stall)
   );

   mje_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .fwd       (fwd),
      .fwd_stall (fwd_stall),
      .pop       (pop),
      .empty     (empty),
      .rsp_node  (rsp_node),
      .rsp_last  (rsp_last)
   );

   assign rsp_node_row  = rsp_node.row;
   assign rsp_node_col  = rsp_node.col;
   assign rsp_node_kind = rsp_node.kind;
   assign rsp_has_north = rsp_node.has_north;
   assign rsp_north_row = rsp_node.north_row;
   assign rsp_has_west  = rsp_node.has_west;
   assign rsp_west_col  = rsp_node.west_col;

endmodule

>>> rtl/mje_front.sv
// Front end: pixel intake, raster counters, line and column record memories,
// node classification. Depends on mje_pkg.
`timescale 1ns / 1ps

module mje_front #(
   parameter int unsigned MAX_WIDTH  = mje_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = mje_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [mje_pkg::PIXEL_W-1:0]         req_pixel,
   input  logic                                csr_we,
   input  logic [mje_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  mje_pkg::cfg_type                    csr_wdata,
   output mje_pkg::bundle_type                 fwd,
   input  logic                                fwd_stall
);

   localparam int unsigned CW = $clog2(MAX_WIDTH);
   localparam int unsigned RW = $clog2(MAX_HEIGHT);

   typedef struct packed {
      logic cur;    // pixel one row up
      logic above;  // pixel two rows up
   } line_type;

   typedef struct packed {
      logic          valid;
      logic [RW-1:0] row;
   } top_type;

   line_type line_mem [2**CW];
   top_type  top_mem  [MAX_WIDTH];

   logic [CW-1:0] last_col_ff, last_col_in;
   logic [RW-1:0] last_row_ff, last_row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // decision stage
   logic          b_valid_ff, b_valid_in;
   logic          b_pix_ff;
   logic [CW-1:0] b_col_ff;
   logic [RW-1:0] b_row_ff;
   line_type      here_ff, nxt_ff;
   logic          prv_ff;
   top_type       top_ff;

   logic          start_found_ff, start_found_in;
   logic          end_found_ff, end_found_in;
   logic          left_valid_ff, left_valid_in;
   logic [CW-1:0] left_col_ff, left_col_in;

   logic accept, b_fire, any_hit, mid_hit, end_hit;
   logic inner, frame_start, sf, ef, lv, prv, node, hn, hw;
   logic top_we;
   top_type top_wdata, top_upd;
   mje_pkg::node_type mid_node, end_node;
   logic [CW-1:0] rd_addr;

   assign accept  = push && !full;
   assign any_hit = mid_hit || end_hit;
   assign b_fire  = b_valid_ff && (!any_hit || !fwd_stall);
   assign full    = b_valid_ff && !b_fire;
   assign rd_addr = CW'(col_ff + CW'(1));

   // config and raster counters
   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (csr_we) begin
         unique case (mje_pkg::csr_index_type'(csr_index))
            mje_pkg::CSR_IMAGE_WIDTH: begin
               last_col_in = CW'(mje_pkg::clamp_last(csr_wdata, MAX_WIDTH));
            end
            mje_pkg::CSR_IMAGE_HEIGHT: begin
               last_row_in = RW'(mje_pkg::clamp_last(csr_wdata, MAX_HEIGHT));
            end
         endcase
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == last_col_ff) begin
            col_in = '0;
            row_in = (row_ff == last_row_ff) ? '0 : RW'(row_ff + RW'(1));
         end else begin
            col_in = CW'(col_ff + CW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= CW'(mje_pkg::clamp_last(mje_pkg::cfg_type'(mje_pkg::CFG_RESET_DIM),
                                                MAX_WIDTH));
         last_row_ff <= RW'(mje_pkg::clamp_last(mje_pkg::cfg_type'(mje_pkg::CFG_RESET_DIM),
                                                MAX_HEIGHT));
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end

   // intake: read this column's record and the next column's line bits
   always_ff @(posedge clock) begin
      if (accept) begin
         b_pix_ff <= (req_pixel != '0);
         b_col_ff <= col_ff;
         b_row_ff <= row_ff;
         nxt_ff   <= line_mem[rd_addr];
         here_ff  <= nxt_ff;
         prv_ff   <= here_ff.cur;
         top_ff   <= top_mem[col_ff];
      end
   end

   // classification: interior nodes of the pixel one row up, start and end nodes of the current pixel
   always_comb begin
      inner       = (b_col_ff != '0) && (b_col_ff != last_col_ff);
      frame_start = (b_row_ff == '0) && (b_col_ff == '0);
      sf          = frame_start ? 1'b0 : start_found_ff;
      ef          = frame_start ? 1'b0 : end_found_ff;
      lv          = (b_col_ff == '0) ? 1'b0 : left_valid_ff;
      prv         = (b_col_ff >= CW'(2)) && prv_ff;

      start_found_in = sf;
      end_found_in   = ef;
      left_valid_in  = lv;
      left_col_in    = left_col_ff;
      top_we         = 1'b0;
      top_wdata      = top_ff;
      node           = 1'b0;
      hn             = 1'b0;
      hw             = 1'b0;
      mid_hit        = 1'b0;
      mid_node       = '0;

      if (b_row_ff == '0) begin
         // row 0 rewrites every column record, which also clears the frame
         mid_hit         = !sf && b_pix_ff && inner;
         top_we          = 1'b1;
         top_wdata.valid = mid_hit;
         top_wdata.row   = '0;
         if (mid_hit) begin
            start_found_in = 1'b1;
            mid_node.col   = mje_pkg::coord_type'(b_col_ff);
            mid_node.kind  = mje_pkg::KIND_START;
         end
      end else if ((b_row_ff >= RW'(2)) && inner) begin
         if (!here_ff.cur) begin
            top_we          = 1'b1;
            top_wdata.valid = 1'b0;
         end else begin
            if (prv) begin
               node = nxt_ff.cur ? (here_ff.above || b_pix_ff) : 1'b1;
            end else begin
               node = nxt_ff.cur ? 1'b1 : (!here_ff.above || !b_pix_ff);
            end
            if (node) begin
               hn                 = here_ff.above && top_ff.valid;
               hw                 = prv && lv;
               mid_hit            = 1'b1;
               mid_node.row       = mje_pkg::coord_type'(RW'(b_row_ff - RW'(1)));
               mid_node.col       = mje_pkg::coord_type'(b_col_ff);
               mid_node.kind      = mje_pkg::KIND_INTERIOR;
               mid_node.has_north = hn;
               mid_node.north_row = hn ? mje_pkg::coord_type'(top_ff.row) : '0;
               mid_node.has_west  = hw;
               mid_node.west_col  = hw ? mje_pkg::coord_type'(left_col_ff) : '0;
               left_valid_in      = nxt_ff.cur;
               left_col_in        = nxt_ff.cur ? b_col_ff : '0;
               top_we             = 1'b1;
               top_wdata.valid    = b_pix_ff;
               top_wdata.row      = RW'(b_row_ff - RW'(1));
            end
         end
      end

      // end node sees the record as just updated by the interior decision
      top_upd            = top_we ? top_wdata : top_ff;
      end_hit            = (b_row_ff == last_row_ff) && inner && !ef && b_pix_ff;
      end_node           = '0;
      end_node.row       = mje_pkg::coord_type'(b_row_ff);
      end_node.col       = mje_pkg::coord_type'(b_col_ff);
      end_node.kind      = mje_pkg::KIND_END;
      end_node.has_north = here_ff.cur && top_upd.valid;
      end_node.north_row = end_node.has_north ? mje_pkg::coord_type'(top_upd.row) : '0;
      if (end_hit) begin
         end_found_in = 1'b1;
      end

      fwd.valid = b_valid_ff && any_hit;
      if (mid_hit) begin
         fwd.two    = end_hit;
         fwd.first  = mid_node;
         fwd.second = end_node;
      end else begin
         fwd.two    = 1'b0;
         fwd.first  = end_node;
         fwd.second = end_node;
      end

      b_valid_in = accept ? 1'b1 : (b_fire ? 1'b0 : b_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         line_mem[b_col_ff].cur   <= b_pix_ff;
         line_mem[b_col_ff].above <= here_ff.cur;
         if (top_we) begin
            top_mem[b_col_ff] <= top_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff     <= 1'b0;
         start_found_ff <= 1'b0;
         end_found_ff   <= 1'b0;
         left_valid_ff  <= 1'b0;
         left_col_ff    <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         if (b_fire) begin
            start_found_ff <= start_found_in;
            end_found_ff   <= end_found_in;
            left_valid_ff  <= left_valid_in;
            left_col_ff    <= left_col_in;
         end
      end
   end

endmodule

>>> rtl/mje_emit.sv
// Back end: two-entry queue of per-pixel node bundles and the result
// serializer that hands out one node per pop. Depends on mje_pkg.
`timescale 1ns / 1ps

module mje_emit (
   input  logic                clock,
   input  logic                reset,
   input  mje_pkg::bundle_type fwd,
   output logic                fwd_stall,
   input  logic                pop,
   output logic                empty,
   output mje_pkg::node_type   rsp_node,
   output logic                rsp_last
);

   mje_pkg::bundle_type q_ff [2];
   mje_pkg::bundle_type head;
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       sel_ff, sel_in;
   logic       enq, pop_ok, done;

   assign fwd_stall = (count_ff == 2'd2);
   assign enq       = fwd.valid && !fwd_stall;
   assign empty     = (count_ff == 2'd0);
   assign head      = q_ff[rptr_ff];
   assign rsp_node  = sel_ff ? head.second : head.first;
   assign rsp_last  = sel_ff || !head.two;
   assign pop_ok    = pop && !empty;
   assign done      = pop_ok && rsp_last;

   always_comb begin
      wptr_in  = enq ? !wptr_ff : wptr_ff;
      rptr_in  = done ? !rptr_ff : rptr_ff;
      count_in = 2'(count_ff + 2'(enq) - 2'(done));
      sel_in   = pop_ok ? !rsp_last : sel_ff;
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wptr_ff] <= fwd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
         sel_ff   <= 1'b0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

>>> rtl/mje_checker.sv
// Port-level checker for the maze graph extractor, bound to the top level.
// Depends on mje_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "maze_junction_graph_extractor_core_macros.svh"

module mje_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        full,
   input logic                        pop,
   input logic                        empty,
   input logic [mje_pkg::COORD_W-1:0] rsp_node_row,
   input logic [mje_pkg::COORD_W-1:0] rsp_node_col,
   input logic [1:0]                  rsp_node_kind,
   input logic                        rsp_has_north,
   input logic [mje_pkg::COORD_W-1:0] rsp_north_row,
   input logic                        rsp_has_west,
   input logic [mje_pkg::COORD_W-1:0] rsp_west_col,
   input logic                        rsp_last
);

   // nothing pending and intake open right after reset
   `MJE_ASSERT_NEXT_ALL(a_reset_idle, clock, reset, empty && !full)

   // an unpopped result node stays put
   `MJE_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop,
      !empty && $stable(rsp_node_row) && $stable(rsp_node_col) && $stable(rsp_last))

   // absent links read as zero
   `MJE_ASSERT_IMPL(a_link_zero, clock, reset, !empty && (!rsp_has_north || !rsp_has_west),
      (rsp_has_north || rsp_north_row == '0) && (rsp_has_west || rsp_west_col == '0))

   // start sits on row 0 unlinked; start and end never get a west link
   `MJE_ASSERT_IMPL(a_border_nodes, clock, reset,
      !empty && rsp_node_kind != mje_pkg::KIND_INTERIOR,
      !rsp_has_west && (rsp_node_kind != mje_pkg::KIND_START ||
                        (!rsp_has_north && rsp_node_row == '0)))

endmodule

bind maze_junction_graph_extractor_core mje_checker u_checker (.*);
